// File: rtl/mvm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix-vector multiply package
// Shared types, widths and helpers for the dense layer matrix-vector block.
// ----------------------------------------------------------------------------
package mvm_pkg;

    localparam int MAX_IN_DEF   = 64;
    localparam int MAX_OUT_DEF  = 64;

    localparam int LEN_W        = 7;
    localparam int IDX_W        = 12;
    localparam int VAL_W        = 16;
    localparam int PROD_W       = 32;
    localparam int ACC_W        = 38;
    localparam int OUT_IDX_W    = 6;
    localparam int WSTORE_DEPTH = 4096;
    localparam int QUEUE_DEPTH  = 2;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 48;

    // Values of the op field carried on s_tuser.
    localparam logic OP_WEIGHT   = 1'b0;
    localparam logic OP_ELEM     = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_IN_LEN  = 1'b0;
    localparam logic CFG_OUT_LEN = 1'b1;

    typedef enum logic [1:0] {
        ITEM_WEIGHT,
        ITEM_ELEM,
        ITEM_ELEM_RUN
    } item_kind_t;

    typedef struct packed {
        item_kind_t              kind;
        logic [IDX_W-1:0]        addr;
        logic signed [VAL_W-1:0] value;
    } queue_entry_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    // A length of zero counts as one; a length above the maximum saturates.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                   input logic [8:0] maxv);
        logic [8:0] v9;
        v9 = 9'(v);
        if (v == '0) begin
            clamp_len = LEN_W'(1);
        end else if (v9 > maxv) begin
            clamp_len = maxv[LEN_W-1:0];
        end else begin
            clamp_len = v;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/mvm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix-vector multiply front end
// Accepts requests, counts vector elements and tags each queue entry.
// ----------------------------------------------------------------------------
module mvm_front
    import mvm_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_clear,
    input  wire logic [LEN_W-1:0]        n_in,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic                    s_op,
    input  wire logic [IDX_W-1:0]        s_weight_index,
    input  wire logic signed [VAL_W-1:0] s_value,
    input  wire logic                    q_ready,
    output logic                         q_push,
    output queue_entry_t                 q_entry
);

    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;
    logic [LEN_W-1:0] count_eff;
    logic             elem_done;

    always_comb begin
        count_eff  = (count_reg >= n_in) ? '0 : count_reg;
        elem_done  = (count_eff + LEN_W'(1)) == n_in;
        s_tready   = q_ready;
        q_push     = s_tvalid && q_ready;
        q_entry.value = s_value;
        case (s_op)
            OP_WEIGHT: begin
                q_entry.kind = ITEM_WEIGHT;
                q_entry.addr = s_weight_index;
            end
            OP_ELEM: begin
                q_entry.kind = elem_done ? ITEM_ELEM_RUN : ITEM_ELEM;
                q_entry.addr = IDX_W'(count_eff);
            end
            default: begin
                q_entry.kind = ITEM_WEIGHT;
                q_entry.addr = s_weight_index;
            end
        endcase

        count_next = count_reg;
        if (cfg_clear) begin
            count_next = '0;
        end else if (q_push && (s_op == OP_ELEM)) begin
            count_next = elem_done ? '0 : count_eff + LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/mvm_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix-vector multiply request queue
// Short register queue that decouples the front end from the compute engine.
// ----------------------------------------------------------------------------
module mvm_fifo
    import mvm_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire queue_entry_t push_entry,
    output logic              push_ready,
    input  wire logic         pop,
    output logic              head_valid,
    output queue_entry_t      head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    queue_entry_t   entries_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wptr_reg;
    logic [PW-1:0]  rptr_reg;
    logic [PW:0]    cnt_reg;

    assign push_ready = cnt_reg != (PW+1)'(QUEUE_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head       = entries_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + (PW+1)'(1);
                2'b01:   cnt_reg <= cnt_reg - (PW+1)'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/mvm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix-vector multiply compute engine
// Owns the weight store and vector buffer and runs the multiply-accumulate.
// ----------------------------------------------------------------------------
module mvm_back
    import mvm_pkg::*;
#(
    parameter int MAX_IN  = MAX_IN_DEF,
    parameter int MAX_OUT = MAX_OUT_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic [LEN_W-1:0]        n_in,
    input  wire logic [LEN_W-1:0]        n_out,
    input  wire logic                    q_valid,
    input  wire queue_entry_t            q_head,
    output logic                         q_pop,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [ACC_W-1:0]      m_value,
    output logic [OUT_IDX_W-1:0]         m_index,
    output logic                         m_last
);

    localparam int IW = (MAX_IN  > 1) ? $clog2(MAX_IN)  : 1;
    localparam int RW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;

    logic signed [VAL_W-1:0] wstore_mem [WSTORE_DEPTH];
    logic signed [VAL_W-1:0] vbuf_mem   [MAX_IN];

    back_state_t       state_reg, state_next;
    logic [IW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;

    logic en, issue, col_last, row_last, wst_we, vbuf_we;

    // Stage 1: memory read data.
    logic                    v1_reg, first1_reg, last1_reg, rowlast1_reg;
    logic [RW-1:0]           row1_reg;
    logic signed [VAL_W-1:0] w_rd_reg, x_rd_reg;
    // Stage 2: product.
    logic                    v2_reg, first2_reg, last2_reg, rowlast2_reg;
    logic [RW-1:0]           row2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    // Stage 3: accumulate.
    logic signed [ACC_W-1:0] acc_reg, acc_base, prod_ext, sum;

    logic                    m_valid_reg, m_last_reg;
    logic signed [ACC_W-1:0] m_value_reg;
    logic [OUT_IDX_W-1:0]    m_index_reg;

    // The whole pipeline holds while a result waits at the output.
    assign en       = !m_valid_reg || m_ready;
    assign issue    = state_reg == BK_RUN;
    assign col_last = (9'(col_reg) + 9'd1) == 9'(n_in);
    assign row_last = (LEN_W'(row_reg) + LEN_W'(1)) == n_out;

    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        addr_next  = addr_reg;
        q_pop      = 1'b0;
        wst_we     = 1'b0;
        vbuf_we    = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        ITEM_WEIGHT: wst_we = 1'b1;
                        ITEM_ELEM:   vbuf_we = 1'b1;
                        ITEM_ELEM_RUN: begin
                            vbuf_we    = 1'b1;
                            state_next = BK_RUN;
                            col_next   = '0;
                            row_next   = '0;
                            addr_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            BK_RUN: begin
                if (en) begin
                    // Row-major layout: the matrix address simply counts up.
                    addr_next = addr_reg + IDX_W'(1);
                    if (col_last) begin
                        col_next = '0;
                        if (row_last) begin
                            state_next = BK_IDLE;
                        end else begin
                            row_next = row_reg + RW'(1);
                        end
                    end else begin
                        col_next = col_reg + IW'(1);
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
        col_reg  <= col_next;
        row_reg  <= row_next;
        addr_reg <= addr_next;
    end

    always_ff @(posedge aclk) begin
        if (wst_we) begin
            wstore_mem[q_head.addr] <= q_head.value;
        end
        if (issue && en) begin
            w_rd_reg <= wstore_mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (vbuf_we) begin
            vbuf_mem[IW'(q_head.addr)] <= q_head.value;
        end
        if (issue && en) begin
            x_rd_reg <= vbuf_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
        if (en) begin
            first1_reg   <= col_reg == '0;
            last1_reg    <= col_last;
            rowlast1_reg <= row_last;
            row1_reg     <= row_reg;
            first2_reg   <= first1_reg;
            last2_reg    <= last1_reg;
            rowlast2_reg <= rowlast1_reg;
            row2_reg     <= row1_reg;
            prod_reg     <= w_rd_reg * x_rd_reg;
        end
    end

    assign acc_base = first2_reg ? '0 : acc_reg;
    assign prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign sum      = acc_base + prod_ext;

    always_ff @(posedge aclk) begin
        if (en && v2_reg) begin
            acc_reg <= sum;
        end
        if (en && v2_reg && last2_reg) begin
            m_value_reg <= sum;
            m_index_reg <= OUT_IDX_W'(row2_reg);
            m_last_reg  <= rowlast2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v2_reg && last2_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_index = m_index_reg;
    assign m_last  = m_last_reg;

endmodule
`default_nettype wire

// File: rtl/matrix_vector_multiply.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix-vector multiply
// Dense layer forward pass: weight writes, vector elements, row dot products.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Moves
// cfg_*     in         write of in_len (index 0) or out_len (index 1)
// s_*       in         request: weight word write or one vector element
// m_*       out        one dot product per matrix row, tlast on the final row
//
// The compute engine writes a weight request or a non-final element into the
// weight store or vector buffer. The element that completes a vector starts
// a run of in_len times out_len multiply-accumulates, one per cycle through
// the single weight-store read port unless m_tready holds the pipeline. The
// front end keeps accepting up to two requests into its queue during a run.
// Reset is synchronous and active low; it clears the element count and the
// control state and sets both lengths to 64, while the weight store and the
// vector buffer hold no defined contents until written. Holding m_tready low
// freezes the whole multiply-accumulate pipeline with the result in place.
//
module matrix_vector_multiply
    import mvm_pkg::*;
#(
    parameter int MAX_IN  = MAX_IN_DEF,
    parameter int MAX_OUT = MAX_OUT_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration write port.
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_addr,
    input  wire logic [LEN_W-1:0]     cfg_data,
    // Request channel.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // weight_index[11:0], value[27:12]
    input  wire logic                 s_tuser,   // op
    // Result channel.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // out_value[37:0], out_index[43:38]
    output logic                      m_tlast
);

    logic [LEN_W-1:0] in_len_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic [LEN_W-1:0] n_in;
    logic [LEN_W-1:0] n_out;

    queue_entry_t push_entry;
    queue_entry_t head;
    logic         push, push_ready, pop, head_valid;

    logic signed [ACC_W-1:0] out_value;
    logic [OUT_IDX_W-1:0]    out_index;

    // Length registers. Any write also drops a partly buffered vector,
    // which the front end handles from the same write enable.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_len_reg  <= LEN_W'(64);
            out_len_reg <= LEN_W'(64);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_IN_LEN:  in_len_reg  <= cfg_data;
                CFG_OUT_LEN: out_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Zero lengths act as one, oversized lengths saturate at the store sizes.
    assign n_in  = clamp_len(in_len_reg,  9'(MAX_IN));
    assign n_out = clamp_len(out_len_reg, 9'(MAX_OUT));

    mvm_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_clear      (cfg_wr_en),
        .n_in           (n_in),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_op           (s_tuser),
        .s_weight_index (s_tdata[11:0]),
        .s_value        (s_tdata[27:12]),
        .q_ready        (push_ready),
        .q_push         (push),
        .q_entry        (push_entry)
    );

    mvm_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mvm_back #(
        .MAX_IN  (MAX_IN),
        .MAX_OUT (MAX_OUT)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .n_in    (n_in),
        .n_out   (n_out),
        .q_valid (head_valid),
        .q_head  (head),
        .q_pop   (pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_value (out_value),
        .m_index (out_index),
        .m_last  (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W - ACC_W - OUT_IDX_W){1'b0}}, out_index, out_value};

endmodule
`default_nettype wire
